// ===== rtl/core/spi_pkg.sv =====
package spi_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int LOT_W           = 8;
   localparam int CODE_W          = 16;
   localparam int KEY_W           = LOT_W + CODE_W;
   localparam int POS_W           = 4;
   localparam int LEN_W           = 5;

   // lot_type sits above item_code, so the packed word is the sort key itself
   typedef struct packed {
      logic [LOT_W-1:0]  lot_type;
      logic [CODE_W-1:0] item_code;
   } spi_req_type;

   typedef struct packed {
      logic [POS_W-1:0] insert_position;
      logic [LEN_W-1:0] queue_length;
      logic             rejected;
   } spi_rsp_type;

   typedef struct packed {
      logic load;      // capture the request key
      logic compare;   // register the per-cell compare flags
      logic insert;    // shift the cells, update the count, issue the result
   } spi_cmd_type;

   typedef struct packed {
      logic full;
   } spi_status_type;

endpackage

// ===== rtl/core/spi_ctrl.sv =====
module spi_ctrl
   import spi_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  spi_status_type status,
   output spi_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_INS  = 3'b100
   } spi_state_type;

   spi_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               // a full queue needs no compare: go straight to the reject
               state_in = status.full ? ST_INS : ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
            state_in    = ST_INS;
         end
         ST_INS: begin
            cmd.insert = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/spi_datapath.sv =====
module spi_datapath
   import spi_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  spi_cmd_type    cmd,
   output spi_status_type status,
   input  spi_req_type    req_data,
   output logic           rsp_valid,
   output spi_rsp_type    rsp_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   logic [KEY_W-1:0]       key_ff;
   logic [KEY_W-1:0]       entry_ff [QUEUE_DEPTH];
   logic [KEY_W-1:0]       entry_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] le_ff, le_in;
   logic [QUEUE_DEPTH-1:0] slot;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       pos;
   logic                   full;
   logic                   rsp_valid_ff, rsp_valid_in;
   spi_rsp_type            rsp_ff, rsp_in;

   assign full        = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.full = full;

   // Held entries are ascending, so the flags form a run of ones from the head.
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic prev_le;

      if (g == 0) begin : g_head
         assign prev_le = 1'b1;
      end else begin : g_body
         assign prev_le = le_ff[g-1];
      end

      assign le_in[g] = (CNT_W'(g) < count_ff) && (entry_ff[g] <= key_ff);
      assign slot[g]  = prev_le && !le_ff[g];

      always_comb begin
         entry_in[g] = entry_ff[g];
         if (!le_ff[g]) begin
            if (prev_le) begin
               entry_in[g] = key_ff;
            end else if (g != 0) begin
               entry_in[g] = entry_ff[(g == 0) ? 0 : g-1];
            end
         end
      end
   end

   always_comb begin
      pos = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (slot[i]) begin
            pos = pos | IDX_W'(i);
         end
      end
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (cmd.insert) begin
         rsp_valid_in = 1'b1;
         if (full) begin
            rsp_in.insert_position = '0;
            rsp_in.queue_length    = LEN_W'(count_ff);
            rsp_in.rejected        = 1'b1;
         end else begin
            count_in               = count_ff + CNT_W'(1);
            rsp_in.insert_position = POS_W'(pos);
            rsp_in.queue_length    = LEN_W'(count_in);
            rsp_in.rejected        = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_data;
      end
      if (cmd.compare) begin
         le_ff <= le_in;
      end
      if (cmd.insert && !full) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            entry_ff[i] <= entry_in[i];
         end
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/sorted_priority_insert_unit.sv =====
// Sorted priority insert unit: keeps up to QUEUE_DEPTH entries in ascending
// order of {lot_type, item_code}; a new entry lands after every held entry
// with a smaller or equal key, so equal keys leave first in, first out. A
// request beat is taken at a rising edge where start is high and busy is low.
// An insert steps through capture, compare in every cell at once, and shift
// and drop into the gap, while a request to a full queue skips the compare;
// the next request is taken in the cycle the result beat shows. The result
// beat is marked by rsp_valid, high for exactly one cycle, and rsp_data holds
// it until the next result; the receiver cannot stall, so capture it then or
// lose it. A full queue rejects the entry with insert_position zero and leaves
// everything unchanged. Position and length wrap to their 4-bit and 5-bit
// fields for larger depths. There is no removal.
module sorted_priority_insert_unit
   import spi_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  spi_req_type req_data,
   output logic        rsp_valid,
   output spi_rsp_type rsp_data
);

   spi_cmd_type    cmd;
   spi_status_type status;

   // Sequence each beat: capture, compare, insert; a full queue skips the compare.
   spi_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Hold the sorted cells, the count and the result register.
   spi_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/spi_checker.sv =====
module spi_checker
   import spi_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input spi_rsp_type rsp_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_insert_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.rejected |-> rsp_data.queue_length != '0)
      else $error("accepted insert reports an empty queue");

   a_reject_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rejected |-> rsp_data.insert_position == '0)
      else $error("rejected beat reports a non-zero position");

endmodule

bind sorted_priority_insert_unit spi_checker u_spi_checker (.*);
